### hdl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash value and the round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned PAD_FILL    = 56;
	localparam logic [7:0]  PAD_MARK    = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef logic [31:0] word_t;
	typedef word_t hash_t [8];

	// handshake between the front end and the compression core
	typedef struct packed {
		logic start;
		logic busy;
	} core_ctl_t;

	function automatic word_t ror(input word_t x, input int unsigned r);
		ror = (x >> r) | (x << (32 - r));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage
`default_nettype wire

### hdl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide message input, eight 32-bit digest words out per message.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction per message byte; has_byte
// marks a real byte, is_end closes the message. Bytes are packed big-endian
// into a 16-word block memory (written one word per four bytes).
// Message bytes are taken while the core is idle; the 64th byte of a block
// starts the compression core, which reads the block back, runs one round
// per cycle and then adds into the chain; input is held off while it is
// busy. The end transaction inserts padding one byte per cycle while the
// core is idle, possibly one extra block, then the digest is emitted as eight
// output transactions (out_valid/out_ready), word 0 first, last_word on
// word 7. A stalled receiver holds the current word; no new input is taken
// until all eight words leave. Reset returns the chain to the initial hash
// value and clears counts; the block memory needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        is_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	typedef enum logic [2:0] {S_TAKE, S_WAIT, S_PAD, S_LEN, S_EMIT} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [23:0] part_q;       // bytes of the word being assembled
	logic [2:0]  lenb_q;
	logic [2:0]  widx_q;
	logic        after_q;      // next pad byte is the 0x80 marker
	logic        busy_q;       // core was started, waiting for busy
	logic [31:0] mem_q [16];
	logic [31:0] rd_data_q;
	logic [3:0]  rd_addr;
	logic        start;
	logic        init_chain;
	logic        core_busy;
	logic [31:0] chain [8];
	logic [7:0]  wbyte;
	logic        wen;
	logic [63:0] bits;
	sha_pkg::core_ctl_t ctl;

	assign bits = {total_q, 3'b000};

	sha_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ctl.start),
		.init_chain (init_chain),
		.busy       (core_busy),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data_q),
		.chain      (chain)
	);

	assign ctl.busy  = core_busy | busy_q;
	assign ctl.start = start;

	// block memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wen && fill_q[1:0] == 2'd3) mem_q[fill_q[5:2]] <= {part_q, wbyte};
		rd_data_q <= mem_q[rd_addr];
	end

	assign in_ready  = (state_q == S_TAKE) && !ctl.busy;
	assign out_valid = (state_q == S_EMIT);
	assign digest_word = chain[widx_q];
	assign word_index  = widx_q;
	assign last_word   = (widx_q == 3'd7);
	assign init_chain  = out_valid && out_ready && last_word;

	always_comb begin
		wen   = 1'b0;
		wbyte = data_byte;
		case (state_q)
			S_TAKE: wen = in_valid && in_ready && has_byte;
			S_PAD: begin
				wen   = !ctl.busy;
				wbyte = after_q ? sha_pkg::PAD_MARK : 8'h00;
			end
			S_LEN: begin
				wen   = 1'b1;
				wbyte = bits[8*(7-lenb_q) +: 8];
			end
			default: wen = 1'b0;
		endcase
		start = wen && (fill_q == 6'(sha_pkg::BLOCK_BYTES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			fill_q  <= '0;
			total_q <= '0;
			lenb_q  <= '0;
			widx_q  <= '0;
			after_q <= 1'b0;
			busy_q  <= 1'b0;
			part_q  <= '0;
		end else begin
			busy_q <= start;
			if (wen) begin
				fill_q <= fill_q + 6'd1;
				part_q <= {part_q[15:0], wbyte};
			end
			case (state_q)
				S_TAKE: begin
					if (in_valid && in_ready) begin
						if (has_byte) total_q <= total_q + 61'd1;
						if (is_end) begin
							state_q <= S_PAD;
							after_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					if (wen) begin
						after_q <= 1'b0;
						if (fill_q == 6'(sha_pkg::PAD_FILL - 1)) begin
							state_q <= S_LEN;
							lenb_q  <= '0;
						end
					end
				end
				S_LEN: begin
					lenb_q <= lenb_q + 3'd1;
					if (lenb_q == 3'd7) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!ctl.busy) begin
						state_q <= S_EMIT;
						widx_q  <= '0;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						widx_q <= widx_q + 3'd1;
						if (last_word) begin
							state_q <= S_TAKE;
							total_q <= '0;
						end
					end
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/sha_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Reads the block from the word memory, runs 64 rounds one per cycle with
// the schedule kept in a 16-word memory, and adds the result into the chain.
// ----------------------------------------------------------------------------
module sha_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        init_chain,
	output logic             busy,
	output logic [3:0]       rd_addr,
	input  wire logic [31:0] rd_data,
	output logic [31:0]      chain [8]
);

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_ADD} state_t;

	state_t       state_q;
	logic [6:0]   cnt_q;
	logic [31:0]  wv_q [8];
	logic [31:0]  w_q [16];   // schedule ring, each slot at its own position
	logic [31:0]  wt;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [5:0]   rnd;

	assign busy    = (state_q != S_IDLE);
	assign rnd     = cnt_q[5:0];
	assign rd_addr = cnt_q[3:0];

	always_comb begin
		if (rnd < 6'd16) begin
			wt = w_q[rnd[3:0]];
		end else begin
			wt = w_q[rnd[3:0]] + sha_pkg::sig0(w_q[rnd[3:0] + 4'd1])
				+ w_q[rnd[3:0] + 4'd9] + sha_pkg::sig1(w_q[rnd[3:0] + 4'd14]);
		end
		t1 = wv_q[7] + sha_pkg::bsig1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ sha_pkg::ROUND_K[rnd] + wt;
		t2 = sha_pkg::bsig0(wv_q[0])
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::INIT_H[i];
		end else begin
			case (state_q)
				S_IDLE: begin
					if (init_chain) begin
						for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::INIT_H[i];
					end
					if (start) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
						for (int i = 0; i < 8; i++) wv_q[i] <= chain[i];
					end
				end
				S_LOAD: begin
					// registered read port: word at cnt-1 arrives now
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != 7'd0) w_q[cnt_q[3:0] - 4'd1] <= rd_data;
					if (cnt_q == 7'd16) begin
						state_q <= S_ROUND;
						cnt_q   <= '0;
					end
				end
				S_ROUND: begin
					w_q[rnd[3:0]] <= wt;
					wv_q[7] <= wv_q[6];
					wv_q[6] <= wv_q[5];
					wv_q[5] <= wv_q[4];
					wv_q[4] <= wv_q[3] + t1;
					wv_q[3] <= wv_q[2];
					wv_q[2] <= wv_q[1];
					wv_q[1] <= wv_q[0];
					wv_q[0] <= t1 + t2;
					cnt_q   <= cnt_q + 7'd1;
					if (rnd == 6'(sha_pkg::ROUNDS - 1)) state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv_q[i];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/sha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for handshake and digest ordering rules.
// ----------------------------------------------------------------------------
module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest word changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word out of place");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest words out of order");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input taken during digest output");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
`default_nettype wire

### tb/sv/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte transactions with random gaps, predicts digests with an
// independent SHA-256 model and checks every digest word in order.
// ----------------------------------------------------------------------------

class digest_scoreboard;
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	int unsigned fill;
	logic [60:0] nbytes;
	logic [31:0] want_word [$];
	logic [2:0]  want_idx [$];
	logic        want_last [$];
	int unsigned errors;

	function new();
		errors = 0;
		restart();
	endfunction

	function void restart();
		chain = sha_pkg::INIT_H;
		fill = 0;
		nbytes = '0;
	endfunction

	function logic [31:0] rr(logic [31:0] x, int r);
		return (x >> r) | (x << (32 - r));
	endfunction

	function void compress();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, s0, s1, t1, t2, x15, x2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		v = chain;
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				x15 = w[(t - 15) & 15];
				x2 = w[(t - 2) & 15];
				s0 = rr(x15, 7) ^ rr(x15, 18) ^ (x15 >> 3);
				s1 = rr(x2, 17) ^ rr(x2, 19) ^ (x2 >> 10);
				wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
				w[t & 15] = wt;
			end
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + wt;
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	function void put(logic [7:0] b);
		blk[fill] = b;
		fill++;
		if (fill == 64) begin
			compress();
			fill = 0;
		end
	endfunction

	// note one accepted input transaction
	function void take(logic [7:0] db, logic hb, logic ie);
		logic [63:0] bits;
		if (hb) begin
			put(db);
			nbytes++;
		end
		if (!ie)
			return;
		bits = {nbytes, 3'b000};
		put(sha_pkg::PAD_MARK);
		while (fill != sha_pkg::PAD_FILL)
			put(8'h00);
		for (int i = 0; i < 8; i++)
			put(bits[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++) begin
			want_word.push_back(chain[i]);
			want_idx.push_back(3'(i));
			want_last.push_back(i == 7);
		end
		restart();
	endfunction

	function void check(logic [31:0] dw, logic [2:0] wi, logic lw);
		if (want_word.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual %h/%0d/%0d",
				$time, dw, wi, lw);
			errors++;
			return;
		end
		if (dw !== want_word[0]) begin
			$display("%0t: digest_word expected %h actual %h", $time, want_word[0], dw);
			errors++;
		end
		if (wi !== want_idx[0]) begin
			$display("%0t: word_index expected %0d actual %0d", $time, want_idx[0], wi);
			errors++;
		end
		if (lw !== want_last[0]) begin
			$display("%0t: last_word expected %0d actual %0d", $time, want_last[0], lw);
			errors++;
		end
		void'(want_word.pop_front());
		void'(want_idx.pop_front());
		void'(want_last.pop_front());
	endfunction

	function int pending();
		return want_word.size();
	endfunction
endclass

module sha256_stream_hasher_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 1'b0;
	logic        is_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard sb = new();
	bit calm = 1'b0;
	int unsigned quiet = 0;
	int unsigned item_count = 0;
	localparam int unsigned WATCHDOG = 20000;

	sha256_stream_hasher u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .is_end(is_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.take(data_byte, has_byte, is_end);
		if (arst_n && out_valid && out_ready)
			sb.check(digest_word, word_index, last_word);
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("FAIL sha256_stream_hasher");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

	// valid stays high between back-to-back transactions; idle cycles drop it
	task automatic send(logic [7:0] db, logic hb, logic ie);
		if (!calm)
			while ($urandom_range(99) < 20) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		data_byte <= db;
		has_byte <= hb;
		is_end <= ie;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		item_count++;
	endtask

	task automatic send_message(int unsigned len);
		for (int i = 0; i < len; i++)
			send(8'($urandom), 1'b1, 1'b0);
		send(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned len;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, one byte on the end transaction, extreme bytes
		send(8'hff, 1'b0, 1'b1);
		send(8'h00, 1'b1, 1'b1);
		send(8'hff, 1'b1, 1'b0);
		send(8'h55, 1'b0, 1'b0);
		send(8'haa, 1'b1, 1'b1);
		// lengths around the padding boundary
		send_message(55);
		send_message(56);
		send_message(63);
		drain();
		send_message(64);

		calm = 1'b1;
		send_message(40);
		calm = 1'b0;

		while (item_count < 320) begin
			case ($urandom_range(9))
				0: len = $urandom_range(30);
				1: len = 0;
				default: len = $urandom_range(20);
			endcase
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0)
					send(8'($urandom), 1'b0, 1'b0);
				send(8'($urandom), 1'b1, 1'b0);
			end
			send(8'($urandom), 1'($urandom), 1'b1);
		end

		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS sha256_stream_hasher");
		else
			$display("FAIL sha256_stream_hasher");
		$finish;
	end
endmodule
